// File: design/three_level_hysteresis_classifier_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the three-level hysteresis classifier
// Shared forms for concurrent checks, clocked on clk with rst as disable.
// ----------------------------------------------------------------------------
`ifndef THREE_LEVEL_HYSTERESIS_CLASSIFIER_MACROS_SVH
`define THREE_LEVEL_HYSTERESIS_CLASSIFIER_MACROS_SVH

// Same-cycle implication.
`define THLC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define THLC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/thlc_pkg.sv
// ----------------------------------------------------------------------------
// thlc_pkg
// Types, codes and band helpers shared by the classifier modules.
// ----------------------------------------------------------------------------
`default_nettype none

package thlc_pkg;

  typedef logic [1:0] band_t;

  localparam band_t BAND_GREEN  = 2'd0;
  localparam band_t BAND_YELLOW = 2'd1;
  localparam band_t BAND_RED    = 2'd2;
  localparam band_t BAND_NONE   = 2'd3;

  localparam logic [1:0] KIND_SCORE    = 2'd0;
  localparam logic [1:0] KIND_OVERRIDE = 2'd1;
  localparam logic [1:0] KIND_CLEAR    = 2'd2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NOOP     = 2'd1;
  localparam logic [1:0] STATUS_CONFLICT = 2'd2;

  localparam logic [1:0] CAUSE_NONE     = 2'd0;
  localparam logic [1:0] CAUSE_HYST     = 2'd1;
  localparam logic [1:0] CAUSE_OVERRIDE = 2'd2;
  localparam logic [1:0] CAUSE_CLEARED  = 2'd3;

  localparam logic [2:0] REG_GREEN_MIN     = 3'd0;
  localparam logic [2:0] REG_YELLOW_MIN    = 3'd1;
  localparam logic [2:0] REG_RISE_MARGIN   = 3'd2;
  localparam logic [2:0] REG_FALL_MARGIN   = 3'd3;
  localparam logic [2:0] REG_CONFIRM_COUNT = 3'd4;
  localparam logic [2:0] REG_MIN_DWELL     = 3'd5;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;
  localparam int THR_BITS       = 16;
  localparam int CNT_BITS       = 8;
  localparam int DWELL_BITS     = 32;

  localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic [THR_BITS-1:0]   green_min;
    logic [THR_BITS-1:0]   yellow_min;
    logic [THR_BITS-1:0]   rise_margin;
    logic [THR_BITS-1:0]   fall_margin;
    logic [CNT_BITS-1:0]   confirm_count;
    logic [DWELL_BITS-1:0] min_dwell;
  } cfg_t;

  typedef struct packed {
    logic                has_state;
    band_t               current_band;
    logic                pending_valid;
    band_t               pending_band;
    logic [CNT_BITS-1:0] pending_count;
    logic                override_active;
    band_t               forced_band;
    logic [THR_BITS-1:0] last_score;
    logic                has_score;
  } ctrl_state_t;

  typedef struct packed {
    logic [1:0]          status;
    logic                changed;
    band_t               from_band;
    band_t               to_band;
    logic [1:0]          cause;
    logic                suppressed;
    logic [CNT_BITS-1:0] confirmations;
    band_t               band;
  } result_t;

  // Raw band of a score; green test first.
  function automatic band_t band_of(cfg_t c, logic [THR_BITS-1:0] s);
    band_t b;
    if (s >= c.green_min) begin
      b = BAND_GREEN;
    end else if (s >= c.yellow_min) begin
      b = BAND_YELLOW;
    end else begin
      b = BAND_RED;
    end
    return b;
  endfunction

  // Lower threshold of a band; red starts at zero.
  function automatic logic [THR_BITS-1:0] band_min(cfg_t c, band_t b);
    logic [THR_BITS-1:0] m;
    case (b)
      BAND_GREEN:  m = c.green_min;
      BAND_YELLOW: m = c.yellow_min;
      default:     m = '0;
    endcase
    return m;
  endfunction

  function automatic band_t eff_band(ctrl_state_t s);
    band_t b;
    if (s.override_active) begin
      b = s.forced_band;
    end else if (s.has_state) begin
      b = s.current_band;
    end else begin
      b = BAND_NONE;
    end
    return b;
  endfunction

endpackage

`default_nettype wire

// File: design/thlc_cfg.sv
// ----------------------------------------------------------------------------
// thlc_cfg
// Configuration register file: thresholds, margins, confirm count, dwell.
// ----------------------------------------------------------------------------
`default_nettype none

module thlc_cfg import thlc_pkg::*; #(
  parameter int SCORE_BITS = 16,
  parameter int TIME_BITS  = 32
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      wr_en,
  input  wire [CFG_INDEX_BITS-1:0] wr_index,
  input  wire [CFG_DATA_BITS-1:0]  wr_data,
  output cfg_t                     cfg
);

  // Writable bits are limited by the score and time widths.
  localparam int SW = (SCORE_BITS < THR_BITS) ? SCORE_BITS : THR_BITS;
  localparam int TW = (TIME_BITS < DWELL_BITS) ? TIME_BITS : DWELL_BITS;

  logic [THR_BITS-1:0]   thr_data;
  logic [DWELL_BITS-1:0] dwell_data;

  assign thr_data   = THR_BITS'(wr_data[SW-1:0]);
  assign dwell_data = DWELL_BITS'(wr_data[TW-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.green_min     <= THR_BITS'(40000);
      cfg.yellow_min    <= THR_BITS'(20000);
      cfg.rise_margin   <= THR_BITS'(1000);
      cfg.fall_margin   <= THR_BITS'(1000);
      cfg.confirm_count <= CNT_BITS'(3);
      cfg.min_dwell     <= DWELL_BITS'(5000);
    end else if (wr_en) begin
      case (wr_index)
        REG_GREEN_MIN:     cfg.green_min     <= thr_data;
        REG_YELLOW_MIN:    cfg.yellow_min    <= thr_data;
        REG_RISE_MARGIN:   cfg.rise_margin   <= thr_data;
        REG_FALL_MARGIN:   cfg.fall_margin   <= thr_data;
        REG_CONFIRM_COUNT: cfg.confirm_count <= wr_data[CNT_BITS-1:0];
        REG_MIN_DWELL:     cfg.min_dwell     <= dwell_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/thlc_judge.sv
// ----------------------------------------------------------------------------
// thlc_judge
// Next-state and result logic for one event against the classifier state.
// ----------------------------------------------------------------------------
`default_nettype none

module thlc_judge import thlc_pkg::*; #(
  parameter int TIME_BITS = 32
) (
  input  cfg_t                 cfg,
  input  ctrl_state_t          st,
  input  wire [TIME_BITS-1:0]  entered_at,
  input  wire [1:0]            kind,
  input  wire [TIME_BITS-1:0]  now,
  input  wire [THR_BITS-1:0]   score,
  input  band_t                ovr_band,
  input  wire                  replace,
  output ctrl_state_t          st_next,
  output logic [TIME_BITS-1:0] entered_at_next,
  output result_t              res
);

  localparam int DW = (TIME_BITS > DWELL_BITS) ? TIME_BITS : DWELL_BITS;

  band_t               raw;
  band_t               raw_last;
  band_t               ob;
  band_t               prior_band;
  logic                up;
  logic                crossed;
  logic [THR_BITS:0]   rise_need;
  logic [THR_BITS:0]   fall_sum;
  logic [CNT_BITS-1:0] cnt_new;
  logic [TIME_BITS-1:0] dwell;
  logic                dwell_short;

  assign raw        = band_of(cfg, score);
  assign raw_last   = band_of(cfg, st.last_score);
  assign ob         = (ovr_band == BAND_NONE) ? BAND_RED : ovr_band;
  assign prior_band = eff_band(st);
  assign up         = raw < st.current_band;

  assign rise_need = {1'b0, band_min(cfg, raw)} + {1'b0, cfg.rise_margin};
  assign fall_sum  = {1'b0, score} + {1'b0, cfg.fall_margin};
  assign crossed   = up ? ({1'b0, score} >= rise_need)
                        : (fall_sum < {1'b0, band_min(cfg, st.current_band)});

  assign cnt_new = (st.pending_valid && st.pending_band == raw)
                   ? ((st.pending_count == CNT_MAX) ? CNT_MAX
                                                    : st.pending_count + CNT_BITS'(1))
                   : CNT_BITS'(1);

  // Elapsed time wraps modulo 2^TIME_BITS.
  assign dwell       = now - entered_at;
  assign dwell_short = DW'(dwell) < DW'(cfg.min_dwell);

  always_comb begin
    st_next         = st;
    entered_at_next = entered_at;
    res             = '0;

    case (kind)
      KIND_SCORE: begin
        st_next.last_score = score;
        st_next.has_score  = 1'b1;
        if (!st.has_state) begin
          st_next.has_state     = 1'b1;
          st_next.current_band  = raw;
          entered_at_next       = now;
          st_next.pending_valid = 1'b0;
          st_next.pending_count = '0;
        end else if (st.override_active) begin
          // judgement on hold while forced
        end else if (raw == st.current_band) begin
          st_next.pending_valid = 1'b0;
          st_next.pending_count = '0;
        end else if (!crossed) begin
          st_next.pending_valid = 1'b0;
          st_next.pending_count = '0;
          res.suppressed        = 1'b1;
        end else begin
          st_next.pending_valid = 1'b1;
          st_next.pending_band  = raw;
          st_next.pending_count = cnt_new;
          if (cnt_new < cfg.confirm_count || dwell_short) begin
            res.suppressed = 1'b1;
          end else begin
            res.changed           = 1'b1;
            res.cause             = CAUSE_HYST;
            res.from_band         = st.current_band;
            res.to_band           = raw;
            res.confirmations     = cnt_new;
            st_next.current_band  = raw;
            entered_at_next       = now;
            st_next.pending_valid = 1'b0;
            st_next.pending_count = '0;
          end
        end
      end
      KIND_OVERRIDE: begin
        if (st.override_active && st.forced_band == ob) begin
          res.status = STATUS_NOOP;
        end else if (st.override_active && !replace) begin
          res.status = STATUS_CONFLICT;
        end else begin
          res.from_band           = (prior_band == BAND_NONE) ? ob : prior_band;
          res.to_band             = ob;
          res.changed             = 1'b1;
          res.cause               = CAUSE_OVERRIDE;
          st_next.override_active = 1'b1;
          st_next.forced_band     = ob;
          entered_at_next         = now;
        end
      end
      KIND_CLEAR: begin
        if (!st.override_active) begin
          res.status = STATUS_NOOP;
        end else begin
          st_next.override_active = 1'b0;
          st_next.forced_band     = BAND_GREEN;
          entered_at_next         = now;
          if (st.has_score) begin
            st_next.has_state     = 1'b1;
            st_next.pending_valid = 1'b0;
            st_next.pending_count = '0;
            st_next.current_band  = raw_last;
            if (raw_last != st.forced_band) begin
              res.changed   = 1'b1;
              res.cause     = CAUSE_CLEARED;
              res.from_band = st.forced_band;
              res.to_band   = raw_last;
            end
          end
        end
      end
      default: ;
    endcase

    res.band = eff_band(st_next);
  end

endmodule

`default_nettype wire

// File: design/three_level_hysteresis_classifier.sv
// ----------------------------------------------------------------------------
// three_level_hysteresis_classifier
// Sorts a link quality score into green / yellow / red with hysteresis,
// debounce, dwell time and manual override.
// ----------------------------------------------------------------------------
//
//  Channel | Signals                                        | Dir | Transfer
//  --------+------------------------------------------------+-----+-----------------
//  in      | in_valid/in_ready, kind, time_now, score,      | in  | valid & ready
//          | override_band, replace                         |     |
//  out     | out_valid/out_ready, status, changed,          | out | valid & ready
//          | from_band, to_band, cause, suppressed,         |     |
//          | confirmations, band                            |     |
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data       | in  | valid & ready
//
//  One event per cycle sustained while the output is not stalled. An event
//  waits in the input register, where the judge logic evaluates it against
//  the current state; state and result register load together, and the
//  result register follows the input register. The next event sees the
//  updated state at once. cfg_ready is always high. Reset clears the state
//  and loads register defaults; a stalled output holds its result and the
//  input register, and in_ready drops only while both are full.
//
`default_nettype none

module three_level_hysteresis_classifier import thlc_pkg::*; #(
  parameter int SCORE_BITS = 16,
  parameter int TIME_BITS  = 32
) (
  input  wire                      clk,
  input  wire                      rst,
  // input events
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire [1:0]                kind,
  input  wire [TIME_BITS-1:0]      time_now,
  input  wire [SCORE_BITS-1:0]     score,
  input  wire [1:0]                override_band,
  input  wire                      replace,
  // results
  output logic                     out_valid,
  input  wire                      out_ready,
  output logic [1:0]               status,
  output logic                     changed,
  output logic [1:0]               from_band,
  output logic [1:0]               to_band,
  output logic [1:0]               cause,
  output logic                     suppressed,
  output logic [7:0]               confirmations,
  output logic [1:0]               band,
  // configuration writes
  input  wire                      cfg_valid,
  output logic                     cfg_ready,
  input  wire [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire [CFG_DATA_BITS-1:0]  cfg_data
);

  // Score and time are limited to 16 and 32 significant bits.
  localparam int SW = (SCORE_BITS < THR_BITS) ? SCORE_BITS : THR_BITS;
  localparam int TW = (TIME_BITS < DWELL_BITS) ? TIME_BITS : DWELL_BITS;

  cfg_t cfg;

  // Input register
  logic                 s1_valid;
  logic [1:0]           s1_kind;
  logic [TIME_BITS-1:0] s1_now;
  logic [THR_BITS-1:0]  s1_score;
  band_t                s1_ovr;
  logic                 s1_replace;

  // Classifier state
  ctrl_state_t          st;
  ctrl_state_t          st_next;
  logic [TIME_BITS-1:0] entered_at;
  logic [TIME_BITS-1:0] entered_at_next;

  result_t res_next;
  result_t res_q;

  logic in_xfer;
  logic s1_advance;

  assign cfg_ready = 1'b1;

  thlc_cfg #(
    .SCORE_BITS (SCORE_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Output slot is free when empty or being taken this cycle.
  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;
  assign in_xfer    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_kind    <= kind;
      s1_now     <= TIME_BITS'(time_now[TW-1:0]);
      s1_score   <= THR_BITS'(score[SW-1:0]);
      s1_ovr     <= override_band;
      s1_replace <= replace;
    end
  end

  thlc_judge #(
    .TIME_BITS (TIME_BITS)
  ) u_judge (
    .cfg             (cfg),
    .st              (st),
    .entered_at      (entered_at),
    .kind            (s1_kind),
    .now             (s1_now),
    .score           (s1_score),
    .ovr_band        (s1_ovr),
    .replace         (s1_replace),
    .st_next         (st_next),
    .entered_at_next (entered_at_next),
    .res             (res_next)
  );

  // State commits only when the event moves into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= '0;
      entered_at <= '0;
    end else if (s1_advance) begin
      st         <= st_next;
      entered_at <= entered_at_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      res_q <= res_next;
    end
  end

  assign status        = res_q.status;
  assign changed       = res_q.changed;
  assign from_band     = res_q.from_band;
  assign to_band       = res_q.to_band;
  assign cause         = res_q.cause;
  assign suppressed    = res_q.suppressed;
  assign confirmations = res_q.confirmations;
  assign band          = res_q.band;

endmodule

`default_nettype wire

// File: design/thlc_checker.sv
// ----------------------------------------------------------------------------
// thlc_checker
// Port-level checks on the classifier result channel, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "three_level_hysteresis_classifier_macros.svh"

module thlc_checker import thlc_pkg::*; (
  input wire       clk,
  input wire       rst,
  input wire       out_valid,
  input wire       out_ready,
  input wire [1:0] status,
  input wire       changed,
  input wire [1:0] from_band,
  input wire [1:0] to_band,
  input wire [1:0] cause,
  input wire       suppressed,
  input wire [7:0] confirmations,
  input wire [1:0] band
);

  `THLC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(band) && $stable(status) && $stable(changed), "result dropped or changed while stalled")

  `THLC_ASSERT_NOW(a_cause_iff_change, out_valid, changed == (cause != CAUSE_NONE), "cause and changed disagree")

  `THLC_ASSERT_NOW(a_refused_quiet, out_valid && status != STATUS_OK, !changed && !suppressed, "no-op or refused event reported activity")

  `THLC_ASSERT_NOW(a_change_lands, out_valid && changed, band == to_band && (cause != CAUSE_HYST || confirmations != 8'd0), "band after change differs from target")

  `THLC_ASSERT_NOW(a_quiet_fields, out_valid && !changed, from_band == BAND_GREEN && to_band == BAND_GREEN && confirmations == 8'd0, "change fields set without a change")

endmodule

bind three_level_hysteresis_classifier thlc_checker u_thlc_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .status        (status),
  .changed       (changed),
  .from_band     (from_band),
  .to_band       (to_band),
  .cause         (cause),
  .suppressed    (suppressed),
  .confirmations (confirmations),
  .band          (band)
);

`default_nettype wire
